/* rtl/core/rsi_pkg.sv */
// rsi_pkg: shared constants for the ray/sphere intersection pipeline
// no dependencies; imported by the interfaces and all rsi modules
package rsi_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

endpackage

/* rtl/core/rsi_if.sv */
// rsi_ray_if / rsi_hit_if: valid/ready channels for ray+sphere beats and hit beats
// depends on rsi_pkg for the default coordinate width
interface rsi_ray_if import rsi_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] origin_x;
	logic signed [CW-1:0] origin_y;
	logic signed [CW-1:0] origin_z;
	logic signed [CW-1:0] dir_x;
	logic signed [CW-1:0] dir_y;
	logic signed [CW-1:0] dir_z;
	logic signed [CW-1:0] center_x;
	logic signed [CW-1:0] center_y;
	logic signed [CW-1:0] center_z;
	logic [CW-2:0]        radius;
	logic [CW-2:0]        t_limit;

	modport source (
		output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output center_x, center_y, center_z, radius, t_limit,
		input ready
	);
	modport sink (
		input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input center_x, center_y, center_z, radius, t_limit,
		output ready
	);
endinterface

interface rsi_hit_if import rsi_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) ();
	logic          valid;
	logic          ready;
	logic          hit;
	logic [CW-2:0] t_out;
	logic          degenerate;

	modport source (output valid, hit, t_out, degenerate, input ready);
	modport sink (input valid, hit, t_out, degenerate, output ready);
endinterface

/* rtl/core/rsi_mul.sv */
// rsi_mul: two-stage signed multiplier built from four half-width partial products
// standalone; used by ray_sphere_intersect for b*b and a*c
module rsi_mul import rsi_pkg::*; #(
	parameter int XW = 2 * COORD_WIDTH_DEF + 3,
	parameter int YW = 2 * COORD_WIDTH_DEF + 3
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [XW-1:0]    x,
	input  logic signed [YW-1:0]    y,
	output logic signed [XW+YW-1:0] p
);
	localparam int HX = (XW + 1) / 2;
	localparam int HY = (YW + 1) / 2;
	localparam int UX = XW - HX;
	localparam int UY = YW - HY;
	localparam int PW = XW + YW;

	logic [XW-1:0] xr, ux;
	logic [YW-1:0] yr, uy;
	logic [HX+HY-1:0] ll_s1;
	logic [HX+UY-1:0] lh_s1;
	logic [UX+HY-1:0] hl_s1;
	logic [UX+UY-1:0] hh_s1;
	logic             sgn_s1;
	logic [PW-1:0]    sum;

	assign xr = x;
	assign yr = y;
	assign ux = x[XW-1] ? (~xr + XW'(1)) : xr;
	assign uy = y[YW-1] ? (~yr + YW'(1)) : yr;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= (HX+HY)'(ux[HX-1:0]) * (HX+HY)'(uy[HY-1:0]);
			lh_s1  <= (HX+UY)'(ux[HX-1:0]) * (HX+UY)'(uy[YW-1:HY]);
			hl_s1  <= (UX+HY)'(ux[XW-1:HX]) * (UX+HY)'(uy[HY-1:0]);
			hh_s1  <= (UX+UY)'(ux[XW-1:HX]) * (UX+UY)'(uy[YW-1:HY]);
			sgn_s1 <= x[XW-1] ^ y[YW-1];
		end
	end

	// low x by high y sits at the y split, high x by low y at the x split
	assign sum = PW'(ll_s1) + (PW'(lh_s1) << HY) + (PW'(hl_s1) << HX)
		+ (PW'(hh_s1) << (HX + HY));

	always_ff @(posedge clk) begin
		if (en) begin
			p <= sgn_s1 ? signed'(~sum + PW'(1)) : signed'(sum);
		end
	end
endmodule

/* rtl/core/rsi_sqrt.sv */
// rsi_sqrt: pipelined integer square root, one result bit per stage
// standalone; carries a sideband tag alongside each beat
module rsi_sqrt import rsi_pkg::*; #(
	parameter int QN = 4 * COORD_WIDTH_DEF - 2,
	parameter int TW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [QN-1:0]     q,
	input  logic [TW-1:0]     tag_in,
	output logic              vld_out,
	output logic [QN/2-1:0]   root,
	output logic [TW-1:0]     tag_out
);
	localparam int RB = QN / 2;

	logic          vld_s  [RB];
	logic [RB:0]   rem_s  [RB];
	logic [RB-1:0] root_s [RB];
	logic [QN-1:0] qr_s   [RB];
	logic [TW-1:0] tag_s  [RB];

	for (genvar g = 0; g < RB; g++) begin : stage
		logic          vld_p;
		logic [RB:0]   rem_p;
		logic [RB-1:0] root_p;
		logic [QN-1:0] qr_p;
		logic [TW-1:0] tag_p;
		logic [RB+2:0] cat, trial;

		if (g == 0) begin : first
			assign vld_p  = vld_in;
			assign rem_p  = '0;
			assign root_p = '0;
			assign qr_p   = q;
			assign tag_p  = tag_in;
		end else begin : chain
			assign vld_p  = vld_s[g-1];
			assign rem_p  = rem_s[g-1];
			assign root_p = root_s[g-1];
			assign qr_p   = qr_s[g-1];
			assign tag_p  = tag_s[g-1];
		end

		// bring down the next two radicand bits, try (2*root)*2 + 1
		assign cat   = {rem_p, qr_p[QN-1 -: 2]};
		assign trial = {1'b0, root_p, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cat >= trial) begin
					rem_s[g]  <= (RB+1)'(cat - trial);
					root_s[g] <= {root_p[RB-2:0], 1'b1};
				end else begin
					rem_s[g]  <= cat[RB:0];
					root_s[g] <= {root_p[RB-2:0], 1'b0};
				end
				qr_s[g]  <= {qr_p[QN-3:0], 2'b00};
				tag_s[g] <= tag_p;
			end
		end
	end

	assign vld_out = vld_s[RB-1];
	assign root    = root_s[RB-1];
	assign tag_out = tag_s[RB-1];

	// remainder never exceeds 2*root, else a root bit was missed
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[RB-1] |-> ({1'b0, rem_s[RB-1]} <= {1'b0, root_s[RB-1], 1'b0}))
		else $error("rsi_sqrt: remainder above 2*root");
endmodule

/* rtl/core/rsi_div.sv */
// rsi_div: two-lane pipelined restoring divider for the near and far roots
// computes floor(n * 2^FRAC / den), zero for n <= 0, saturated to the format max
module rsi_div import rsi_pkg::*; #(
	parameter int CW   = COORD_WIDTH_DEF,
	parameter int FRAC = FRAC_BITS_DEF,
	parameter int NW   = 2 * COORD_WIDTH_DEF + 3,
	parameter int AW   = 2 * COORD_WIDTH_DEF,
	parameter int TW   = COORD_WIDTH_DEF + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  logic signed [NW-1:0] num_near,
	input  logic signed [NW-1:0] num_far,
	input  logic [AW-1:0]        den,
	input  logic [TW-1:0]        tag_in,
	output logic                 vld_out,
	output logic [CW-2:0]        t_near,
	output logic [CW-2:0]        t_far,
	output logic [TW-1:0]        tag_out
);
	localparam int QB = CW - 1;
	localparam int XW = NW - 1 + FRAC;
	localparam int HW = XW - QB;
	localparam int MW = (HW > AW) ? HW : AW;

	logic          vld_s [QB+1];
	logic [AW-1:0] den_s [QB+1];
	logic [TW-1:0] tag_s [QB+1];
	logic [QB-1:0] t_lane [2];
	logic          pos_o [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int k = 1; k <= QB; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			tag_s[0] <= tag_in;
			for (int k = 1; k <= QB; k++) begin
				den_s[k] <= den_s[k-1];
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : lane
		logic signed [NW-1:0] n_in;
		logic [XW-1:0]        x;
		logic [HW-1:0]        hi;
		logic [AW-1:0]        rem_s [QB+1];
		logic [QB-1:0]        lo_s  [QB+1];
		logic [QB-1:0]        q_s   [QB+1];
		logic                 pos_s [QB+1];
		logic                 sat_s [QB+1];

		assign n_in = (l == 0) ? num_near : num_far;
		assign x    = {n_in[NW-2:0], {FRAC{1'b0}}};
		assign hi   = x[XW-1:QB];

		// quotient overflows the format when the upper part already reaches den
		always_ff @(posedge clk) begin
			if (en) begin
				pos_s[0] <= !n_in[NW-1] && (n_in != '0);
				sat_s[0] <= MW'(hi) >= MW'(den);
				rem_s[0] <= AW'(hi);
				lo_s[0]  <= x[QB-1:0];
				q_s[0]   <= '0;
			end
		end

		for (genvar k = 1; k <= QB; k++) begin : step
			logic [AW:0] cat;
			logic        ge;

			assign cat = {rem_s[k-1], lo_s[k-1][QB-1]};
			assign ge  = cat >= {1'b0, den_s[k-1]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? AW'(cat - {1'b0, den_s[k-1]}) : cat[AW-1:0];
					q_s[k]   <= {q_s[k-1][QB-2:0], ge};
					lo_s[k]  <= {lo_s[k-1][QB-2:0], 1'b0};
					pos_s[k] <= pos_s[k-1];
					sat_s[k] <= sat_s[k-1];
				end
			end
		end

		assign pos_o[l]  = pos_s[QB];
		assign t_lane[l] = !pos_s[QB] ? '0 : (sat_s[QB] ? {QB{1'b1}} : q_s[QB]);
	end

	assign vld_out = vld_s[QB];
	assign t_near  = t_lane[0];
	assign t_far   = t_lane[1];
	assign tag_out = tag_s[QB];

	// far numerator is never below the near one
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QB] && pos_o[0] |-> pos_o[1])
		else $error("rsi_div: near root positive but far root not");
endmodule

/* rtl/core/ray_sphere_intersect.sv */
// ray_sphere_intersect: one ray against one sphere per beat, signed fixed point
// channels: ray (sink) carries origin, direction, center, radius and the current
//   nearest distance t_limit; res (source) returns hit, t_out and degenerate
// every input beat gives exactly one result beat, in order
// pipeline: the integer square root resolves one bit per stage (2*COORD_WIDTH-1
//   stages); each root divider has COORD_WIDTH stages, a saturation check and then
//   one quotient bit per stage
// throughput: one beat per cycle while res is taken
// stall: when a result sits in the output register and res.ready is low, the
//   whole pipeline holds; nothing is dropped or repeated, ray.ready falls
// reset: arst_n clears every valid bit, the pipeline comes up empty
// t_out equals t_limit unless a positive root below t_limit is found;
//   a zero direction reports degenerate with no hit
module ray_sphere_intersect import rsi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rsi_ray_if.sink   ray,
	rsi_hit_if.source res
);
	localparam int CW  = COORD_WIDTH;
	localparam int TL  = CW - 1;
	localparam int AW  = 2 * CW;
	localparam int BW  = 2 * CW + 3;
	localparam int NW  = 2 * CW + 3;
	localparam int QW  = 4 * CW + 7;
	localparam int QN  = 4 * CW - 2;
	localparam int RB  = QN / 2;
	localparam int PDD = 2 * CW;
	localparam int PDW = 2 * CW + 1;
	localparam int PWW = 2 * CW + 2;
	localparam int PRR = 2 * CW - 2;
	localparam int STW = AW + BW + TL + 2;
	localparam int DTW = TL + 2;

	logic en;
	logic res_vld_q, hit_q, deg_q;
	logic [TL-1:0] t_q;

	assign en        = !res_vld_q || res.ready;
	assign ray.ready = en;

	// s1: capture, form w = origin - center
	logic                 vld_s1;
	logic signed [CW-1:0] d_s1 [3];
	logic signed [CW:0]   w_s1 [3];
	logic [TL-1:0]        r_s1, tl_s1;

	// s2: coordinate products
	logic                  vld_s2;
	logic signed [PDD-1:0] dd_s2 [3];
	logic signed [PDW-1:0] dw_s2 [3];
	logic signed [PWW-1:0] ww_s2 [3];
	logic [PRR-1:0]        rr_s2;
	logic [TL-1:0]         tl_s2;

	// s3: a = d.d, b = d.w, c = w.w - r^2
	logic                 vld_s3, deg_s3;
	logic [AW-1:0]        a_s3;
	logic signed [BW-1:0] b_s3, c_s3;
	logic [TL-1:0]        tl_s3;
	logic signed [AW:0]   a_sx;

	// s4, s5: sideband alongside the wide multipliers
	logic                 vld_s4, vld_s5, deg_s4, deg_s5;
	logic [AW-1:0]        a_s4, a_s5;
	logic signed [BW-1:0] b_s4, b_s5;
	logic [TL-1:0]        tl_s4, tl_s5;
	logic signed [2*BW-1:0]   bb_s5;
	logic signed [AW+BW:0]    ac_s5;

	// s6: discriminant
	logic                 vld_s6, deg_s6, neg_s6;
	logic [AW-1:0]        a_s6;
	logic signed [BW-1:0] b_s6;
	logic [TL-1:0]        tl_s6;
	logic [QN-1:0]        qn_s6;
	logic signed [QW-1:0] q_full;

	// sqrt outputs
	logic                 sq_vld, sq_deg, sq_neg;
	logic [RB-1:0]        sq_root;
	logic [STW-1:0]       sq_tag;
	logic [AW-1:0]        sq_a;
	logic signed [BW-1:0] sq_b;
	logic [TL-1:0]        sq_tl;

	// s7: root numerators
	logic                 vld_s7;
	logic signed [NW-1:0] nn_s7, nf_s7;
	logic [AW-1:0]        a_s7;
	logic [DTW-1:0]       tag_s7;

	// divider outputs
	logic           dv_vld, dv_deg, dv_neg, hit_c;
	logic [TL-1:0]  dv_tn, dv_tf, dv_tl, sel;
	logic [DTW-1:0] dv_tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= ray.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= sq_vld;
			res_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= ray.dir_x;
			d_s1[1] <= ray.dir_y;
			d_s1[2] <= ray.dir_z;
			w_s1[0] <= {ray.origin_x[CW-1], ray.origin_x} - {ray.center_x[CW-1], ray.center_x};
			w_s1[1] <= {ray.origin_y[CW-1], ray.origin_y} - {ray.center_y[CW-1], ray.center_y};
			w_s1[2] <= {ray.origin_z[CW-1], ray.origin_z} - {ray.center_z[CW-1], ray.center_z};
			r_s1    <= ray.radius;
			tl_s1   <= ray.t_limit;

			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= PDD'(d_s1[i]) * PDD'(d_s1[i]);
				dw_s2[i] <= PDW'(d_s1[i]) * PDW'(w_s1[i]);
				ww_s2[i] <= PWW'(w_s1[i]) * PWW'(w_s1[i]);
			end
			rr_s2 <= PRR'(r_s1) * PRR'(r_s1);
			tl_s2 <= tl_s1;

			a_s3   <= AW'(dd_s2[0]) + AW'(dd_s2[1]) + AW'(dd_s2[2]);
			b_s3   <= BW'(dw_s2[0]) + BW'(dw_s2[1]) + BW'(dw_s2[2]);
			c_s3   <= BW'(ww_s2[0]) + BW'(ww_s2[1]) + BW'(ww_s2[2])
				- signed'(BW'(rr_s2));
			deg_s3 <= (dd_s2[0] == '0) && (dd_s2[1] == '0) && (dd_s2[2] == '0);
			tl_s3  <= tl_s2;

			a_s4   <= a_s3;
			b_s4   <= b_s3;
			tl_s4  <= tl_s3;
			deg_s4 <= deg_s3;
			a_s5   <= a_s4;
			b_s5   <= b_s4;
			tl_s5  <= tl_s4;
			deg_s5 <= deg_s4;

			a_s6   <= a_s5;
			b_s6   <= b_s5;
			tl_s6  <= tl_s5;
			deg_s6 <= deg_s5;
			neg_s6 <= q_full[QW-1];
			// a nonnegative discriminant stays below a*r^2, well inside QN bits
			qn_s6  <= q_full[QW-1] ? '0 : q_full[QN-1:0];

			nn_s7  <= -NW'(sq_b) - signed'(NW'(sq_root));
			nf_s7  <= -NW'(sq_b) + signed'(NW'(sq_root));
			a_s7   <= sq_a;
			tag_s7 <= {sq_tl, sq_deg, sq_neg};

			hit_q <= hit_c;
			t_q   <= hit_c ? sel : dv_tl;
			deg_q <= dv_deg;
		end
	end

	assign a_sx = {1'b0, a_s3};

	rsi_mul #(.XW(BW), .YW(BW)) u_mul_bb (
		.clk (clk),
		.en  (en),
		.x   (b_s3),
		.y   (b_s3),
		.p   (bb_s5)
	);

	rsi_mul #(.XW(AW + 1), .YW(BW)) u_mul_ac (
		.clk (clk),
		.en  (en),
		.x   (a_sx),
		.y   (c_s3),
		.p   (ac_s5)
	);

	assign q_full = QW'(bb_s5) - QW'(ac_s5);

	rsi_sqrt #(.QN(QN), .TW(STW)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s6),
		.q       (qn_s6),
		.tag_in  ({a_s6, b_s6, tl_s6, deg_s6, neg_s6}),
		.vld_out (sq_vld),
		.root    (sq_root),
		.tag_out (sq_tag)
	);

	assign {sq_a, sq_b, sq_tl, sq_deg, sq_neg} = sq_tag;

	rsi_div #(.CW(CW), .FRAC(FRAC_BITS), .NW(NW), .AW(AW), .TW(DTW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s7),
		.num_near (nn_s7),
		.num_far  (nf_s7),
		.den      (a_s7),
		.tag_in   (tag_s7),
		.vld_out  (dv_vld),
		.t_near   (dv_tn),
		.t_far    (dv_tf),
		.tag_out  (dv_tag)
	);

	assign {dv_tl, dv_deg, dv_neg} = dv_tag;

	// near root first, far root when the near one is not positive
	assign sel   = (dv_tn != '0) ? dv_tn : dv_tf;
	assign hit_c = !dv_deg && !dv_neg && (sel != '0) && (sel < dv_tl);

	assign res.valid      = res_vld_q;
	assign res.hit        = hit_q;
	assign res.t_out      = t_q;
	assign res.degenerate = deg_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && hit_q |-> !deg_q && (t_q != '0))
		else $error("ray_sphere_intersect: hit with zero distance or degenerate ray");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && hit_q |-> (t_q != {TL{1'b1}}))
		else $error("ray_sphere_intersect: saturated root reported as hit");
endmodule

/* tb/sv/ray_sphere_intersect_tb.sv */
// ray_sphere_intersect_tb: self-checking bench for the ray/sphere intersection pipeline
// depends on rsi_pkg, rsi_ray_if / rsi_hit_if and ray_sphere_intersect
// drives directed and random ray beats, predicts each result and compares in order
module ray_sphere_intersect_tb import rsi_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW        = COORD_WIDTH_DEF;
	localparam int FB        = FRAC_BITS_DEF;
	localparam int LATENCY   = 3 * CW + 7;
	localparam int MAX_CYCLES = 600000;
	localparam logic [CW-2:0] T_MAX = '1;

	typedef struct {
		logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
		logic [CW-2:0]        radius, t_limit;
	} ray_t;

	typedef struct {
		logic          hit;
		logic [CW-2:0] t_out;
		logic          degenerate;
	} hit_t;

	logic clk;
	logic arst_n;
	rsi_ray_if #(.CW(CW)) ray_ch ();
	rsi_hit_if #(.CW(CW)) res_ch ();

	ray_sphere_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.ray    (ray_ch),
		.res    (res_ch)
	);

	hit_t expected_hits[$];
	int   mismatches = 0;
	int   cycles = 0;
	bit   no_idle = 1'b0;
	bit   hold_rx = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// floor(n * 2^FB / a), capped; zero when n is not positive
	function automatic logic [CW-2:0] root_dist(logic signed [191:0] n, logic [191:0] a);
		logic [191:0] quo;
		if (n <= 0)
			return '0;
		quo = ($unsigned(n) << FB) / a;
		return (quo > 192'(T_MAX)) ? T_MAX : quo[CW-2:0];
	endfunction

	function automatic hit_t sphere_hit(ray_t r);
		logic signed [191:0] dv[3], wv[3];
		logic signed [191:0] b, c, q;
		logic [191:0]        a, s, cand, rad;
		logic [CW-2:0]       t;
		hit_t                h;
		h.hit = 1'b0;
		h.t_out = r.t_limit;
		h.degenerate = 1'b0;
		dv[0] = 192'(r.dx); dv[1] = 192'(r.dy); dv[2] = 192'(r.dz);
		wv[0] = 192'(r.ox) - 192'(r.cx);
		wv[1] = 192'(r.oy) - 192'(r.cy);
		wv[2] = 192'(r.oz) - 192'(r.cz);
		a = '0; b = '0; c = '0;
		for (int i = 0; i < 3; i++) begin
			a += $unsigned(dv[i] * dv[i]);
			b += dv[i] * wv[i];
			c += wv[i] * wv[i];
		end
		if (a == '0) begin
			h.degenerate = 1'b1;
			return h;
		end
		rad = 192'(r.radius);
		c = c - $signed(rad * rad);
		q = b * b - $signed(a) * c;
		if (q < 0)
			return h;
		// square root resolved over 64 bits only
		s = '0;
		for (int k = 63; k >= 0; k--) begin
			cand = s;
			cand[k] = 1'b1;
			if ($unsigned(q) >= cand * cand)
				s = cand;
		end
		t = root_dist(-b - $signed(s), a);
		if (t == '0)
			t = root_dist(-b + $signed(s), a);
		if (t > '0 && t < r.t_limit) begin
			h.hit = 1'b1;
			h.t_out = t;
		end
		return h;
	endfunction

	task automatic send_ray(ray_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(14);
		@(negedge clk);
		if (gap > 0) begin
			ray_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		ray_ch.origin_x = r.ox; ray_ch.origin_y = r.oy; ray_ch.origin_z = r.oz;
		ray_ch.dir_x = r.dx; ray_ch.dir_y = r.dy; ray_ch.dir_z = r.dz;
		ray_ch.center_x = r.cx; ray_ch.center_y = r.cy; ray_ch.center_z = r.cz;
		ray_ch.radius = r.radius;
		ray_ch.t_limit = r.t_limit;
		ray_ch.valid = 1'b1;
		do @(posedge clk); while (!ray_ch.ready);
		expected_hits.push_back(sphere_hit(r));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		ray_ch.valid = 1'b0;
		wait (expected_hits.size() == 0);
	endtask

	function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
			int cx, int cy, int cz, int rad, int tl);
		ray_t r;
		r.ox = ox; r.oy = oy; r.oz = oz;
		r.dx = dx; r.dy = dy; r.dz = dz;
		r.cx = cx; r.cy = cy; r.cz = cz;
		r.radius = (CW-1)'(rad); r.t_limit = (CW-1)'(tl);
		return r;
	endfunction

	// ray aimed near a sphere, coordinates within about +-64 units
	function automatic ray_t aimed_ray();
		ray_t r;
		int   sh;
		r.cx = $signed($urandom_range(1 << 23)) - (1 << 22);
		r.cy = $signed($urandom_range(1 << 23)) - (1 << 22);
		r.cz = $signed($urandom_range(1 << 23)) - (1 << 22);
		r.ox = $signed($urandom_range(1 << 23)) - (1 << 22);
		r.oy = $signed($urandom_range(1 << 23)) - (1 << 22);
		r.oz = $signed($urandom_range(1 << 23)) - (1 << 22);
		sh = $urandom_range(8);
		r.dx = ((r.cx - r.ox) >>> sh) + $signed($urandom_range(1 << 18)) - (1 << 17);
		r.dy = ((r.cy - r.oy) >>> sh) + $signed($urandom_range(1 << 18)) - (1 << 17);
		r.dz = ((r.cz - r.oz) >>> sh) + $signed($urandom_range(1 << 18)) - (1 << 17);
		r.radius = (CW-1)'($urandom_range(1 << 22));
		case ($urandom_range(3))
			0: r.t_limit = T_MAX;
			1: r.t_limit = (CW-1)'($urandom_range(1 << 24));
			default: r.t_limit = (CW-1)'($urandom);
		endcase
		return r;
	endfunction

	function automatic ray_t noise_ray();
		ray_t r;
		r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
		r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
		r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
		r.radius = (CW-1)'($urandom);
		r.t_limit = (CW-1)'($urandom);
		if ($urandom_range(9) == 0) begin
			r.dx = '0; r.dy = '0; r.dz = '0;
		end
		return r;
	endfunction

	function automatic ray_t mixed_ray();
		return ($urandom_range(9) < 7) ? aimed_ray() : noise_ray();
	endfunction

	task automatic test_directed();
		localparam int ONE = 1 << FB;
		localparam int MINV = 32'h8000_0000;
		localparam int MAXV = 32'h7fff_ffff;
		// zero direction
		send_ray(mk_ray(0, 0, 0, 0, 0, 0, 5 * ONE, 0, 0, ONE, MAXV));
		// plain hit straight ahead
		send_ray(mk_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, 2 * ONE, MAXV));
		// same hit but at exactly the current nearest distance
		send_ray(mk_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, 2 * ONE, 8 * ONE));
		// limit of zero never lets a hit through
		send_ray(mk_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, 2 * ONE, 0));
		// clear miss, negative discriminant
		send_ray(mk_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 10 * ONE, 0, ONE, MAXV));
		// tangent ray
		send_ray(mk_ray(0, ONE, 0, ONE, 0, 0, 10 * ONE, 0, 0, ONE, MAXV));
		// origin inside the sphere, far root taken
		send_ray(mk_ray(0, 0, 0, 0, ONE, 0, 0, 0, 0, 3 * ONE, MAXV));
		// sphere behind the ray
		send_ray(mk_ray(0, 0, 0, -ONE, 0, 0, 10 * ONE, 0, 0, 2 * ONE, MAXV));
		// tiny direction toward far sphere, root saturates
		send_ray(mk_ray(0, 0, 0, 1, 0, 0, MAXV, 0, 0, ONE, MAXV));
		// zero radius on axis
		send_ray(mk_ray(0, 0, 0, 0, 0, ONE, 0, 0, 4 * ONE, 0, MAXV));
		// field extremes
		send_ray(mk_ray(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 0, 0));
		send_ray(mk_ray(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
		send_ray(mk_ray(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
		send_ray(mk_ray(MAXV, 0, MINV, MINV, 1, -1, MINV, 0, MAXV, MAXV, MAXV));
		send_ray(mk_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0, MAXV, MAXV));
		send_ray(mk_ray(0, 0, 0, MINV, 0, 0, MAXV, 0, 0, MAXV, MAXV));
		send_ray(mk_ray(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, MAXV, MAXV));
		wait_drained();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			// stretches with no idling on either side
			if (i % 300 == 0)
				no_idle = 1'b1;
			else if (i % 300 == 60)
				no_idle = 1'b0;
			send_ray(mixed_ray());
		end
		no_idle = 1'b0;
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_rx = 1'b1;
		no_idle = 1'b1;
		for (int i = 0; i < 200; i++)
			send_ray(mixed_ray());
		no_idle = 1'b0;
		wait_drained();
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int n;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_rx) begin
				res_ch.ready = 1'b0;
				repeat (500) @(negedge clk);
				hold_rx = 1'b0;
			end
			n = no_idle ? 0 : $urandom_range(14);
			if (n > 0) begin
				res_ch.ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		hit_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: hit=%0b t_out=%h degenerate=%0b",
						res_ch.hit, res_ch.t_out, res_ch.degenerate);
			end else begin
				e = expected_hits.pop_front();
				if (res_ch.hit !== e.hit || res_ch.t_out !== e.t_out ||
						res_ch.degenerate !== e.degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp hit=%0b t=%h deg=%0b, got hit=%0b t=%h deg=%0b",
							e.hit, e.t_out, e.degenerate,
							res_ch.hit, res_ch.t_out, res_ch.degenerate);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		ray_ch.valid = 1'b0;
		ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
		ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
		ray_ch.center_x = '0; ray_ch.center_y = '0; ray_ch.center_z = '0;
		ray_ch.radius = '0;
		ray_ch.t_limit = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_backpressure();
		test_random(1230);

		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && expected_hits.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

/* ray_sphere_intersect.f */
rtl/core/rsi_pkg.sv
rtl/core/rsi_if.sv
rtl/core/rsi_mul.sv
rtl/core/rsi_sqrt.sv
rtl/core/rsi_div.sv
rtl/core/ray_sphere_intersect.sv
tb/sv/ray_sphere_intersect_tb.sv
